// ----- hdl/frx_pkg.sv -----
// ----------------------------------------------------------------------------
// frx_pkg
// Shared types, constants and the byte-wide CRC-32 update for the sync /
// length / CRC-32 frame receiver.
// ----------------------------------------------------------------------------
package frx_pkg;

   // Hard limit on the payload length, independent of the register
   localparam int unsigned MAX_PAYLOAD = 4096;

   // Field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEN_W    = 13;
   localparam int unsigned HLEN_W   = 16;
   localparam int unsigned TICK_W   = 16;
   localparam int unsigned PIDX_W   = 12;
   localparam int unsigned CRC_W    = 32;
   // Position counter: header, up to a 16-bit length and four checksum bytes
   localparam int unsigned POS_W    = 17;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Header lengths in bytes (sync pair, optional ids, length pair)
   localparam logic [POS_W-1:0] HEAD_IDS    = POS_W'(6);
   localparam logic [POS_W-1:0] HEAD_NO_IDS = POS_W'(4);

   localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

   // Input word kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SYNC_FIRST  = 3'd0,
      REG_SYNC_SECOND = 3'd1,
      REG_USE_IDS     = 3'd2,
      REG_OWN_ID      = 3'd3,
      REG_MAX_PAYLOAD = 3'd4,
      REG_TIMEOUT_MS  = 3'd5
   } reg_index_type;

   // Configuration as seen by the deframer
   typedef struct packed {
      logic [BYTE_W-1:0] sync_first;
      logic [BYTE_W-1:0] sync_second;
      logic              use_ids;
      logic [BYTE_W-1:0] own_id;
      logic [LEN_W-1:0]  max_payload;
      logic [TICK_W-1:0] timeout_ms;
   } cfg_type;

   // One result word
   typedef struct packed {
      logic              handled_ok;
      logic              payload_valid;
      logic [BYTE_W-1:0] payload_byte;
      logic [PIDX_W-1:0] payload_index;
      logic              frame_end;
      logic              frame_good;
      logic [BYTE_W-1:0] source_id;
      logic [LEN_W-1:0]  frame_length;
   } rsp_type;

   // Reflected CRC-32 update by one byte
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- hdl/frx_if.sv -----
// ----------------------------------------------------------------------------
// frx_if
// Valid/ready channels of the frame receiver: input word, result word and
// configuration write.
// ----------------------------------------------------------------------------
interface frx_req_if;
   import frx_pkg::*;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, kind, rx_byte, input ready);
   modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface frx_rsp_if;
   import frx_pkg::*;
   logic              valid;
   logic              ready;
   logic              handled_ok;
   logic              payload_valid;
   logic [BYTE_W-1:0] payload_byte;
   logic [PIDX_W-1:0] payload_index;
   logic              frame_end;
   logic              frame_good;
   logic [BYTE_W-1:0] source_id;
   logic [LEN_W-1:0]  frame_length;
   modport source (output valid, handled_ok, payload_valid, payload_byte, payload_index,
                   frame_end, frame_good, source_id, frame_length, input ready);
   modport sink   (input valid, handled_ok, payload_valid, payload_byte, payload_index,
                   frame_end, frame_good, source_id, frame_length, output ready);
endinterface

interface frx_csr_if;
   import frx_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/frx_csr_regs.sv -----
// ----------------------------------------------------------------------------
// frx_csr_regs
// Configuration registers of the frame receiver, written through the
// configuration channel; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module frx_csr_regs (
   input  logic            clock,
   input  logic            reset,
   frx_csr_if.sink         csr_ch,
   output frx_pkg::cfg_type cfg
);
   import frx_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Always take configuration words
   assign csr_ch.ready = 1'b1;

   // Decode the register index and merge the written field
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_SYNC_FIRST:  cfg_in.sync_first  = csr_ch.data[BYTE_W-1:0];
            REG_SYNC_SECOND: cfg_in.sync_second = csr_ch.data[BYTE_W-1:0];
            REG_USE_IDS:     cfg_in.use_ids     = csr_ch.data[0];
            REG_OWN_ID:      cfg_in.own_id      = csr_ch.data[BYTE_W-1:0];
            REG_MAX_PAYLOAD: cfg_in.max_payload = csr_ch.data[LEN_W-1:0];
            REG_TIMEOUT_MS:  cfg_in.timeout_ms  = csr_ch.data[TICK_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= '0;
         cfg_ff.sync_second <= '0;
         cfg_ff.use_ids     <= 1'b0;
         cfg_ff.own_id      <= '0;
         cfg_ff.max_payload <= LEN_W'(MAX_PAYLOAD);
         cfg_ff.timeout_ms  <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/frx_deframer.sv -----
// ----------------------------------------------------------------------------
// frx_deframer
// Input register, frame state and result register. Each word is decoded in
// one pass from the input register into the result register.
// ----------------------------------------------------------------------------
module frx_deframer (
   input  logic             clock,
   input  logic             reset,
   input  frx_pkg::cfg_type cfg,
   frx_req_if.sink          req_ch,
   frx_rsp_if.source        rsp_ch
);
   import frx_pkg::*;

   // Input register
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_kind_ff;
   logic [BYTE_W-1:0] s1_byte_ff;

   // Result register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   // Frame state
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [TICK_W-1:0] idle_ff, idle_in;
   logic [BYTE_W-1:0] src_ff, src_in;
   logic [BYTE_W-1:0] dst_ff, dst_in;
   logic [HLEN_W-1:0] len_ff, len_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [CRC_W-1:0]  chk_ff, chk_in;

   logic             advance;
   logic             req_accept;
   logic             timed_out;
   logic [POS_W-1:0] pos_step;
   logic [POS_W-1:0] pos_cur;
   logic [POS_W-1:0] head_w;
   logic [POS_W-1:0] end_pos;
   logic [POS_W-1:0] pidx_w;
   logic [POS_W-1:0] ci_w;
   logic [CRC_W-1:0] crc_first;
   logic [CRC_W-1:0] crc_next;

   // Move the held word into the result register when that is free
   assign advance      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_accept   = req_ch.valid && req_ch.ready;

   // Position of this byte, restarting the frame after an idle gap
   assign pos_step  = pos_ff + POS_W'(1);
   assign timed_out = (pos_step != POS_W'(1)) && !cfg.timeout_ms[TICK_W-1] &&
                      (idle_ff > {1'b0, cfg.timeout_ms[TICK_W-2:0]});
   assign pos_cur   = timed_out ? POS_W'(1) : pos_step;

   assign head_w    = cfg.use_ids ? HEAD_IDS : HEAD_NO_IDS;
   assign end_pos   = head_w + POS_W'(len_ff);
   assign pidx_w    = pos_cur - POS_W'(1) - head_w;
   assign ci_w      = pos_cur - POS_W'(1) - end_pos;
   assign crc_first = crc_byte(CRC_INIT, s1_byte_ff);
   assign crc_next  = crc_byte(crc_ff, s1_byte_ff);

   // Decode one word against the frame state
   always_comb begin
      logic [HLEN_W-1:0] len_new;
      logic [CRC_W-1:0]  chk_new;
      len_new  = len_ff;
      chk_new  = chk_ff;
      pos_in   = pos_ff;
      idle_in  = idle_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      len_in   = len_ff;
      crc_in   = crc_ff;
      chk_in   = chk_ff;
      out_in   = '0;
      out_in.handled_ok = 1'b1;

      if (s1_kind_ff == KIND_TICK) begin
         // Count idle ticks, saturating
         if (idle_ff != '1) begin
            idle_in = idle_ff + TICK_W'(1);
         end
      end else begin
         idle_in = '0;
         pos_in  = pos_cur;
         if (pos_cur == POS_W'(1)) begin
            // First sync byte
            if (s1_byte_ff != cfg.sync_first) begin
               pos_in = '0;
               out_in.handled_ok = 1'b0;
            end else begin
               crc_in = crc_first;
            end
         end else if (pos_cur == POS_W'(2)) begin
            // Second sync byte; a repeated first sync restarts the hunt
            if (s1_byte_ff == cfg.sync_second) begin
               crc_in = crc_next;
            end else if (s1_byte_ff == cfg.sync_first) begin
               pos_in = POS_W'(1);
               crc_in = crc_first;
            end else begin
               pos_in = '0;
               out_in.handled_ok = 1'b0;
            end
         end else if (pos_cur <= head_w) begin
            // Header: ids and little-endian length
            crc_in = crc_next;
            if (cfg.use_ids) begin
               if (pos_cur == POS_W'(3)) begin
                  src_in = s1_byte_ff;
               end else if (pos_cur == POS_W'(4)) begin
                  dst_in = s1_byte_ff;
               end else if (pos_cur == POS_W'(5)) begin
                  len_new = {len_ff[HLEN_W-1:BYTE_W], s1_byte_ff};
               end else begin
                  len_new = {s1_byte_ff, len_ff[BYTE_W-1:0]};
               end
            end else begin
               if (pos_cur == POS_W'(3)) begin
                  len_new = {len_ff[HLEN_W-1:BYTE_W], s1_byte_ff};
               end else begin
                  len_new = {s1_byte_ff, len_ff[BYTE_W-1:0]};
                  src_in  = '0;
               end
            end
            len_in = len_new;
            // Drop a frame whose length is over either limit
            if ((pos_cur == head_w) &&
                ((len_new > HLEN_W'(cfg.max_payload)) || (len_new > HLEN_W'(MAX_PAYLOAD)))) begin
               pos_in = '0;
               out_in.handled_ok = 1'b0;
            end
         end else if (pos_cur <= end_pos) begin
            // Payload byte, passed straight through
            crc_in = crc_next;
            out_in.payload_valid = 1'b1;
            out_in.payload_byte  = s1_byte_ff;
            out_in.payload_index = pidx_w[PIDX_W-1:0];
         end else begin
            // Checksum byte, little-endian; the fourth one ends the frame
            chk_new[ci_w[1:0]*BYTE_W +: BYTE_W] = s1_byte_ff;
            chk_in = chk_new;
            if (ci_w >= POS_W'(3)) begin
               pos_in = '0;
               out_in.frame_end    = 1'b1;
               out_in.frame_good   = ((crc_ff ^ CRC_INIT) == chk_new) &&
                                     (!cfg.use_ids || (dst_ff == cfg.own_id));
               out_in.source_id    = cfg.use_ids ? src_ff : '0;
               out_in.frame_length = len_ff[LEN_W-1:0];
            end
         end
      end
   end

   // Input register valid: load on accept, drain on advance
   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // Result register valid: fill on advance, drain when taken
   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control and frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
         idle_ff      <= '0;
         src_ff       <= '0;
         dst_ff       <= '0;
         len_ff       <= '0;
         crc_ff       <= CRC_INIT;
         chk_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            pos_ff  <= pos_in;
            idle_ff <= idle_in;
            src_ff  <= src_in;
            dst_ff  <= dst_in;
            len_ff  <= len_in;
            crc_ff  <= crc_in;
            chk_ff  <= chk_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff <= req_ch.kind;
         s1_byte_ff <= req_ch.rx_byte;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.handled_ok    = out_ff.handled_ok;
   assign rsp_ch.payload_valid = out_ff.payload_valid;
   assign rsp_ch.payload_byte  = out_ff.payload_byte;
   assign rsp_ch.payload_index = out_ff.payload_index;
   assign rsp_ch.frame_end     = out_ff.frame_end;
   assign rsp_ch.frame_good    = out_ff.frame_good;
   assign rsp_ch.source_id     = out_ff.source_id;
   assign rsp_ch.frame_length  = out_ff.frame_length;

   // Input stalls only while both registers are full and the output is held
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && out_valid_ff && !rsp_ch.ready))
      else $error("input stalled with room in the pipeline");

   // A tick yields a plain accepted word
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      (advance && (s1_kind_ff == KIND_TICK)) |=>
         (out_valid_ff && out_ff.handled_ok && !out_ff.payload_valid && !out_ff.frame_end))
      else $error("tick produced a non-empty result");

   // Verdict fields stay clear outside the frame end
   a_verdict_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.frame_end) |->
         (!out_ff.frame_good && (out_ff.source_id == '0) && (out_ff.frame_length == '0)))
      else $error("verdict fields set without frame end");

   // A finished frame returns the receiver to the hunt
   a_end_restarts_hunt: assert property (@(posedge clock) disable iff (reset)
      (advance && out_in.frame_end) |=> (pos_ff == '0))
      else $error("frame end did not restart the hunt");

   // A payload byte is never also a rejection or a frame end
   a_payload_exclusive: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.payload_valid) |-> (out_ff.handled_ok && !out_ff.frame_end))
      else $error("payload word flagged as rejected or frame end");

endmodule

// ----- hdl/sync_length_crc32_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// sync_length_crc32_frame_receiver
// Receives sync / ids / length / payload / CRC-32 frames one byte or tick
// word at a time and returns one result word for each input word.
// ----------------------------------------------------------------------------
// Path: input register, then result register, which drives rsp_ch.
// Throughput: one word per cycle while rsp_ch is ready; the byte-wide CRC
// update and header decode sit between the input and result registers.
// Reset: synchronous, active high; clears the frame state to the sync hunt,
// sets the CRC to all ones and loads the register defaults. No clearing pass.
// ----------------------------------------------------------------------------
module sync_length_crc32_frame_receiver (
   input  logic      clock,
   input  logic      reset,
   frx_req_if.sink   req_ch,
   frx_rsp_if.source rsp_ch,
   frx_csr_if.sink   csr_ch
);
   import frx_pkg::*;

   cfg_type cfg;

   // Configuration registers
   frx_csr_regs u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // Frame decode datapath
   frx_deframer u_deframer (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sync / length / CRC-32 frame receiver. A queue
// of words (bytes and millisecond ticks) feeds a clocked driver. The driver
// predicts one result word for each accepted word. A clocked monitor compares
// every result word field by field with the oldest prediction. Both sides
// idle in random bursts. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb;
   import frx_pkg::*;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] rx_byte;
   } rx_word_type;

   // Indexes past the register list; writes to them must be ignored
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam logic [TICK_W-1:0]    TIMEOUT_OFF  = 16'hFFFF;
   localparam int unsigned          LONG_HOLD    = 300;

   logic clock;
   logic reset;

   frx_req_if req_ch();
   frx_rsp_if rsp_ch();
   frx_csr_if csr_ch();

   sync_length_crc32_frame_receiver u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Register copies, reset values
   logic [BYTE_W-1:0] cfg_sync_first  = '0;
   logic [BYTE_W-1:0] cfg_sync_second = '0;
   logic              cfg_use_ids     = 1'b0;
   logic [BYTE_W-1:0] cfg_own_id      = '0;
   logic [LEN_W-1:0]  cfg_max_len     = LEN_W'(4096);
   logic [TICK_W-1:0] cfg_timeout     = TIMEOUT_OFF;

   // Deframer state, reset values
   int unsigned       rx_pos   = 0;
   logic [TICK_W-1:0] idle_cnt = '0;
   logic [BYTE_W-1:0] hdr_src  = '0;
   logic [BYTE_W-1:0] hdr_dst  = '0;
   logic [HLEN_W-1:0] hdr_len  = '0;
   logic [CRC_W-1:0]  crc_acc  = CRC_INIT;
   logic [CRC_W-1:0]  crc_rx   = '0;

   rx_word_type rx_words[$];
   rsp_type     due_results[$];
   rx_word_type next_word;
   rsp_type     want_rsp;

   int unsigned words_queued   = 0;
   int unsigned words_accepted = 0;
   int unsigned fail_count     = 0;
   int unsigned send_gap       = 0;
   int unsigned recv_hold      = 0;
   logic        send_idle_en;
   logic        recv_idle_en;
   logic        quiet_tail;
   logic        long_hold_req;

   // Reflected CRC-32, one data bit per step, LSB first
   function automatic logic [CRC_W-1:0] crc32_shift(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      logic             fb;
      c = crc;
      for (int k = 0; k < BYTE_W; k++) begin
         fb = c[0] ^ b[k];
         c  = (c >> 1) ^ (fb ? CRC_POLY : '0);
      end
      return c;
   endfunction

   // Advance the deframer by one word and return the result word it yields
   function automatic rsp_type deframe_step(input logic kind, input logic [BYTE_W-1:0] b);
      rsp_type     r;
      int unsigned head;
      int unsigned ci;
      r = '0;
      r.handled_ok = 1'b1;
      if (kind == KIND_TICK) begin
         if (idle_cnt != '1) begin
            idle_cnt++;
         end
      end else begin
         rx_pos++;
         // A long enough gap turns this byte into a first byte
         if (rx_pos != 1 && !cfg_timeout[TICK_W-1] && idle_cnt > cfg_timeout) begin
            rx_pos = 1;
         end
         idle_cnt = '0;
         head = cfg_use_ids ? HEAD_IDS : HEAD_NO_IDS;
         if (rx_pos == 1) begin
            if (b != cfg_sync_first) begin
               rx_pos = 0;
               r.handled_ok = 1'b0;
            end else begin
               crc_acc = crc32_shift(CRC_INIT, b);
            end
         end else if (rx_pos == 2) begin
            if (b == cfg_sync_second) begin
               crc_acc = crc32_shift(crc_acc, b);
            end else if (b == cfg_sync_first) begin
               // Restart the hunt on a repeated first sync byte
               rx_pos  = 1;
               crc_acc = crc32_shift(CRC_INIT, b);
            end else begin
               rx_pos = 0;
               r.handled_ok = 1'b0;
            end
         end else if (rx_pos <= head) begin
            crc_acc = crc32_shift(crc_acc, b);
            if (cfg_use_ids) begin
               case (rx_pos)
                  3: hdr_src = b;
                  4: hdr_dst = b;
                  5: hdr_len[7:0] = b;
                  default: hdr_len[15:8] = b;
               endcase
            end else if (rx_pos == 3) begin
               hdr_len[7:0] = b;
            end else begin
               hdr_len[15:8] = b;
               hdr_src = '0;
            end
            // Drop frames whose length exceeds either limit
            if (rx_pos == head && (hdr_len > cfg_max_len || hdr_len > MAX_PAYLOAD)) begin
               rx_pos = 0;
               r.handled_ok = 1'b0;
            end
         end else if (rx_pos <= head + hdr_len) begin
            crc_acc = crc32_shift(crc_acc, b);
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            r.payload_index = PIDX_W'(rx_pos - 1 - head);
         end else begin
            ci = rx_pos - 1 - head - hdr_len;
            crc_rx[(ci & 3) * 8 +: 8] = b;
            if (ci >= 3) begin
               rx_pos = 0;
               r.frame_end  = 1'b1;
               r.frame_good = ((crc_acc ^ CRC_INIT) == crc_rx) &&
                              (!cfg_use_ids || hdr_dst == cfg_own_id);
               r.source_id    = cfg_use_ids ? hdr_src : '0;
               r.frame_length = LEN_W'(hdr_len);
            end
         end
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned seen);
      if (want != seen) begin
         $error("%s: expected %0h, got %0h", name, want, seen);
         fail_count++;
      end
   endfunction

   task automatic push_word(input logic kind, input logic [BYTE_W-1:0] b);
      rx_words.push_back('{kind: kind, rx_byte: b});
      words_queued++;
   endtask

   task automatic push_tick();
      push_word(KIND_TICK, BYTE_W'($urandom));
   endtask

   // Queue a frame built from the current sync bytes; cut > 0 keeps only that
   // many bytes, bad_crc corrupts one checksum bit, ticks sprinkles ticks
   task automatic queue_frame(input int unsigned len, input int unsigned cut,
                              input logic bad_crc, input logic ids,
                              input logic [BYTE_W-1:0] dst, input logic ticks);
      logic [BYTE_W-1:0] fb[$];
      logic [CRC_W-1:0]  c;
      int unsigned       n;
      int unsigned       n_payload;
      fb.push_back(cfg_sync_first);
      fb.push_back(cfg_sync_second);
      if (ids) begin
         fb.push_back(BYTE_W'($urandom));
         fb.push_back(dst);
      end
      fb.push_back(BYTE_W'(len));
      fb.push_back(BYTE_W'(len >> 8));
      n_payload = (len > MAX_PAYLOAD) ? 0 : len;
      for (int i = 0; i < n_payload; i++) begin
         fb.push_back(BYTE_W'($urandom));
      end
      c = CRC_INIT;
      foreach (fb[i]) begin
         c = crc32_shift(c, fb[i]);
      end
      c ^= CRC_INIT;
      if (bad_crc) begin
         c[$urandom_range(0, CRC_W - 1)] ^= 1'b1;
      end
      for (int k = 0; k < 4; k++) begin
         fb.push_back(c[k * 8 +: 8]);
      end
      n = (cut == 0 || cut > fb.size()) ? fb.size() : cut;
      for (int i = 0; i < n; i++) begin
         if (ticks && $urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 3)) push_tick();
         end
         push_word(KIND_BYTE, fb[i]);
      end
   endtask

   // Write one register and mirror it; call only while the block is idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         REG_SYNC_FIRST:  cfg_sync_first  = value[BYTE_W-1:0];
         REG_SYNC_SECOND: cfg_sync_second = value[BYTE_W-1:0];
         REG_USE_IDS:     cfg_use_ids     = value[0];
         REG_OWN_ID:      cfg_own_id      = value[BYTE_W-1:0];
         REG_MAX_PAYLOAD: cfg_max_len     = value[LEN_W-1:0];
         REG_TIMEOUT_MS:  cfg_timeout     = value[TICK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [BYTE_W-1:0] sf, input logic [BYTE_W-1:0] ss,
                             input logic ids, input logic [BYTE_W-1:0] own,
                             input logic [LEN_W-1:0] maxl, input logic [TICK_W-1:0] tmo);
      write_reg(REG_SYNC_FIRST, CSR_DATA_W'(sf));
      write_reg(REG_SYNC_SECOND, CSR_DATA_W'(ss));
      write_reg(REG_USE_IDS, CSR_DATA_W'(ids));
      write_reg(REG_OWN_ID, CSR_DATA_W'(own));
      write_reg(REG_MAX_PAYLOAD, CSR_DATA_W'(maxl));
      write_reg(REG_TIMEOUT_MS, tmo);
   endtask

   task automatic random_config();
      logic [BYTE_W-1:0] sf;
      logic [BYTE_W-1:0] ss;
      logic [LEN_W-1:0]  maxl;
      logic [TICK_W-1:0] tmo;
      sf = BYTE_W'($urandom);
      ss = ($urandom_range(0, 3) == 0) ? sf : BYTE_W'($urandom);
      case ($urandom_range(0, 4))
         0: maxl = LEN_W'($urandom_range(0, 4));
         1: maxl = LEN_W'($urandom_range(5, 40));
         2: maxl = LEN_W'(MAX_PAYLOAD);
         3: maxl = '1;
         default: maxl = LEN_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0: tmo = TIMEOUT_OFF;
         1: tmo = 16'h8000 | TICK_W'($urandom);
         2: tmo = TICK_W'($urandom_range(0, 4));
         3: tmo = TICK_W'($urandom_range(5, 40));
         default: tmo = 16'h7FFF;
      endcase
      set_config(sf, ss, 1'($urandom), BYTE_W'($urandom), maxl, tmo);
      if ($urandom_range(0, 2) == 0) begin
         write_reg(REG_SPARE_HI, CSR_DATA_W'($urandom));
      end
   endtask

   // Mostly well-formed frames with random content, the rest noise and
   // broken frames
   task automatic random_traffic(input int unsigned n);
      int unsigned start;
      int unsigned lim;
      int unsigned len;
      int unsigned pick;
      int unsigned head;
      start = words_queued;
      while (words_queued - start < n) begin
         lim  = (cfg_max_len < MAX_PAYLOAD) ? cfg_max_len : MAX_PAYLOAD;
         head = cfg_use_ids ? HEAD_IDS : HEAD_NO_IDS;
         pick = $urandom_range(0, 99);
         case ($urandom_range(0, 14))
            0: len = (lim < 64) ? lim : $urandom_range(0, 64);
            1: len = $urandom_range(0, (lim < 200) ? lim : 200);
            default: len = $urandom_range(0, (lim < 20) ? lim : 20);
         endcase
         if (pick < 70) begin
            queue_frame(len, 0, $urandom_range(0, 7) == 0, cfg_use_ids,
                        ($urandom_range(0, 3) != 0) ? cfg_own_id : BYTE_W'($urandom),
                        $urandom_range(0, 2) == 0);
         end else if (pick < 78) begin
            repeat ($urandom_range(1, 6)) begin
               push_word(KIND_BYTE, ($urandom_range(0, 2) == 0) ? cfg_sync_first
                                                                 : BYTE_W'($urandom));
            end
         end else if (pick < 86) begin
            repeat ($urandom_range(1, 40)) push_tick();
         end else if (pick < 94) begin
            // Truncate a frame, or build it with the other header layout
            if ($urandom_range(0, 1) == 0) begin
               queue_frame(len, $urandom_range(1, head + len + 3), 1'b0, cfg_use_ids,
                           cfg_own_id, 1'b0);
            end else begin
               queue_frame(len, 0, 1'b0, !cfg_use_ids, cfg_own_id, 1'b0);
            end
         end else if (lim < 16'hFFFF) begin
            len = ($urandom_range(0, 1) == 0) ? lim + 1 : $urandom_range(lim + 1, 16'hFFFF);
            queue_frame(len, head + $urandom_range(0, 3), 1'b0, cfg_use_ids, cfg_own_id, 1'b0);
         end
      end
   endtask

   // Hold until every queued word is taken and every result word has come
   task automatic wait_drained();
      do @(posedge clock);
      while (words_accepted != words_queued || due_results.size() != 0);
   endtask

   always #4 clock = ~clock;

   // Driver: predict on acceptance, then offer the next word or idle
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            due_results.push_back(deframe_step(req_ch.kind, req_ch.rx_byte));
            words_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (rx_words.size() > 0) begin
               next_word = rx_words.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.kind    <= next_word.kind;
               req_ch.rx_byte <= next_word.rx_byte;
               if (send_idle_en && !quiet_tail && $urandom_range(0, 9) == 0) begin
                  send_gap = $urandom_range(1, 18);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result word, stall in bursts or on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_results.size() == 0) begin
               $error("result word with no expectation pending");
               fail_count++;
            end else begin
               want_rsp = due_results.pop_front();
               check_field("handled_ok", want_rsp.handled_ok, rsp_ch.handled_ok);
               check_field("payload_valid", want_rsp.payload_valid, rsp_ch.payload_valid);
               check_field("payload_byte", want_rsp.payload_byte, rsp_ch.payload_byte);
               check_field("payload_index", want_rsp.payload_index, rsp_ch.payload_index);
               check_field("frame_end", want_rsp.frame_end, rsp_ch.frame_end);
               check_field("frame_good", want_rsp.frame_good, rsp_ch.frame_good);
               check_field("source_id", want_rsp.source_id, rsp_ch.source_id);
               check_field("frame_length", want_rsp.frame_length, rsp_ch.frame_length);
            end
         end
         if (long_hold_req) begin
            recv_hold = LONG_HOLD;
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_ch.ready <= 1'b0;
         end else if (recv_idle_en && !quiet_tail && $urandom_range(0, 9) == 0) begin
            recv_hold = $urandom_range(1, 18) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Stimulus sequence
   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.kind    = KIND_BYTE;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = REG_SYNC_FIRST;
      csr_ch.data    = '0;
      send_idle_en   = 1'b1;
      recv_idle_en   = 1'b1;
      quiet_tail     = 1'b0;
      long_hold_req  = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Basic frames: tick, sync mismatch, repeated first sync, empty frame,
      // bad checksum, second sync mismatch
      set_config(8'hAA, 8'h55, 1'b0, 8'h00, LEN_W'(MAX_PAYLOAD), TIMEOUT_OFF);
      push_word(KIND_TICK, 8'hFF);
      push_word(KIND_BYTE, 8'h00);
      push_word(KIND_BYTE, 8'hAA);
      queue_frame(0, 0, 1'b0, 1'b0, 8'h00, 1'b0);
      queue_frame(1, 0, 1'b1, 1'b0, 8'h00, 1'b0);
      push_word(KIND_BYTE, 8'hAA);
      push_word(KIND_BYTE, 8'h13);
      wait_drained();

      // Ids on, zero length limit, zero timeout; leave a frame open in its
      // checksum so the next layout change cuts it short
      set_config(8'h00, 8'hFF, 1'b1, 8'hFF, '0, '0);
      queue_frame(0, 0, 1'b0, 1'b1, 8'hFF, 1'b0);
      queue_frame(0, 0, 1'b0, 1'b1, 8'h12, 1'b0);
      queue_frame(1, 6, 1'b0, 1'b1, 8'hFF, 1'b0);
      push_word(KIND_BYTE, 8'h00);
      push_tick();
      push_word(KIND_BYTE, 8'hFF);
      push_word(KIND_BYTE, 8'h00);
      queue_frame(0, 8, 1'b0, 1'b1, 8'hFF, 1'b0);
      wait_drained();

      // Ids off mid-frame, negative timeout other than -1, widest limit,
      // writes past the register list
      set_config(8'h00, 8'hFF, 1'b0, 8'h00, '1, 16'hFFFE);
      write_reg(REG_SPARE_LO, 16'hFFFF);
      write_reg(REG_SPARE_HI, 16'h0000);
      push_word(KIND_BYTE, 8'h5A);
      queue_frame(MAX_PAYLOAD + 1, 4, 1'b0, 1'b0, 8'h00, 1'b0);
      queue_frame(16'hFFFF, 4, 1'b0, 1'b0, 8'h00, 1'b0);
      repeat (5) push_tick();
      queue_frame(3, 0, 1'b0, 1'b0, 8'h00, 1'b0);
      wait_drained();

      // Largest accepted length cut short, then gaps at and just past the
      // timeout
      send_idle_en <= 1'b0;
      recv_idle_en <= 1'b0;
      set_config(8'hFF, 8'h00, 1'b1, 8'h5C, LEN_W'(MAX_PAYLOAD), 16'h0003);
      queue_frame(MAX_PAYLOAD, 40, 1'b0, 1'b1, 8'h5C, 1'b0);
      repeat (4) push_tick();
      queue_frame(2, 0, 1'b0, 1'b1, 8'h5C, 1'b0);
      queue_frame(2, 4, 1'b0, 1'b1, 8'h5C, 1'b0);
      repeat (3) push_tick();
      push_word(KIND_BYTE, 8'h00);
      repeat (4) push_tick();
      push_word(KIND_BYTE, 8'hFF);
      wait_drained();

      // Random phases: one long receiver hold-off, one sender pause midway,
      // no idling in the last
      for (int ph = 0; ph < 5; ph++) begin
         random_config();
         send_idle_en <= (ph != 1) && ($urandom_range(0, 3) != 0);
         recv_idle_en <= ($urandom_range(0, 3) != 0);
         quiet_tail   <= (ph == 4);
         if (ph == 2) begin
            random_traffic(175);
            wait_drained();
            random_traffic(175);
         end else begin
            random_traffic(350);
            if (ph == 1) begin
               long_hold_req <= 1'b1;
               @(posedge clock);
               long_hold_req <= 1'b0;
            end
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #30_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
